// ----- design/assert_macros.svh -----
// Assertion macros used by the encoder top level.
// Defining ASSERT_OFF turns every check into an empty statement.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
`define ASSERT_CLK(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");
`define ASSERT_NEVER(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("forbidden condition seen");
`else
`define ASSERT_CLK(lbl, clk, rst_n, prop)
`define ASSERT_NEVER(lbl, clk, rst_n, cond)
`endif

`endif

// ----- design/cre_pkg.sv -----
// Shared types and constants of the carryless range encoder.
// No dependencies; used by every module of the block.
package cre_pkg;

    localparam int WORD_W   = 32;
    localparam int DEN_W    = 16;
    localparam int BYTE_W   = 8;
    localparam int OP_W     = 2;
    localparam int TOP_BITS = 24;
    localparam int MAX_EMIT = 4;
    localparam int CNT_W    = 3;

    localparam logic [OP_W-1:0] OP_INTERVAL = 2'd0;
    localparam logic [OP_W-1:0] OP_BINARY   = 2'd1;
    localparam logic [OP_W-1:0] OP_FLUSH    = 2'd2;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

endpackage

// ----- design/cre_div.sv -----
// Bit-serial restoring divider: 32-bit dividend by 16-bit divisor, one bit per cycle.
// Depends on cre_pkg. A zero divisor yields an all-ones quotient.
module cre_div (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [cre_pkg::WORD_W-1:0]   i_dividend,
    input  logic [cre_pkg::DEN_W-1:0]    i_divisor,
    output logic [cre_pkg::WORD_W-1:0]   o_quotient,
    output cre_pkg::t_div_stat           o_stat
);
    import cre_pkg::*;

    logic [WORD_W-1:0] r_quo;
    logic [DEN_W-1:0]  r_rem;
    logic [DEN_W-1:0]  r_den;
    logic [4:0]        r_cnt;
    logic              r_busy;
    logic              r_done;

    logic [DEN_W:0] w_trial;
    logic [DEN_W:0] w_diff;
    logic           w_ge;

    assign w_trial = {r_rem, r_quo[WORD_W-1]};
    assign w_diff  = w_trial - {1'b0, r_den};
    assign w_ge    = (w_trial >= {1'b0, r_den});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_quo  <= i_dividend;
                r_rem  <= '0;
                r_den  <= i_divisor;
                r_cnt  <= '0;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_rem <= w_ge ? w_diff[DEN_W-1:0] : w_trial[DEN_W-1:0];
                r_quo <= {r_quo[WORD_W-2:0], w_ge};
                r_cnt <= r_cnt + 5'd1;
                if (r_cnt == 5'(WORD_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_quotient  = r_quo;
    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;

endmodule

// ----- design/cre_mul.sv -----
// Shared 32 by 32 multiplier keeping the low 32 bits of the product, registered.
// Depends on cre_pkg.
module cre_mul (
    input  logic                       i_clk,
    input  logic                       i_en,
    input  logic [cre_pkg::WORD_W-1:0] i_a,
    input  logic [cre_pkg::WORD_W-1:0] i_b,
    output logic [cre_pkg::WORD_W-1:0] o_prod
);
    import cre_pkg::*;

    logic [WORD_W-1:0] r_prod;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod <= WORD_W'(i_a * i_b);
        end
    end

    assign o_prod = r_prod;

endmodule

// ----- design/carryless_range_encoder.sv -----
// Top level of the carryless range encoder: sequencer, interval state, output register.
// Depends on cre_pkg, cre_div, cre_mul and assert_macros.svh.
//
//  channel | direction | handshake          | payload
//  input   | in        | i_valid / o_stall  | i_op i_cum_low i_cum_high i_total i_f0 i_shift i_bit_req
//  output  | out       | o_valid / i_stall  | o_out_byte o_last
//
// An interval encode keeps o_stall high through the bit-serial divider and the multiplies in
// S_MUL1 and S_MUL2, a binary encode through the multiply in S_BIN; both then pass S_NORM and
// S_LOOK once per emitted byte, or S_NORM alone when no byte is due. A flush emits four bytes.
// The next transfer is taken back in S_IDLE. The block takes one item at a time.
// Reset is synchronous and sets low to zero and range to all ones.
// A stalled output holds its byte; the sequencer waits while that byte is stalled.
`include "assert_macros.svh"

module carryless_range_encoder #(
    parameter int BOTTOM_BITS = 15
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_stall,
    input  logic [cre_pkg::OP_W-1:0]   i_op,
    input  logic [14:0]                i_cum_low,
    input  logic [15:0]                i_cum_high,
    input  logic [15:0]                i_total,
    input  logic [15:0]                i_f0,
    input  logic [4:0]                 i_shift,
    input  logic                       i_bit_req,
    output logic                       o_valid,
    input  logic                       i_stall,
    output logic [cre_pkg::BYTE_W-1:0] o_out_byte,
    output logic                       o_last
);
    import cre_pkg::*;

    localparam logic [WORD_W-1:0] BOT_VALUE = WORD_W'(1) << BOTTOM_BITS;
    localparam logic [WORD_W-1:0] BOT_MASK  = BOT_VALUE - WORD_W'(1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV,
        S_MUL1,
        S_MUL2,
        S_BIN,
        S_NORM,
        S_LOOK,
        S_FLUSH
    } t_state;

    t_state r_state, n_state;
    logic [WORD_W-1:0] r_low, n_low;
    logic [WORD_W-1:0] r_range, n_range;
    logic [WORD_W-1:0] r_q, n_q;
    logic [14:0]       r_cum_low, n_cum_low;
    logic [15:0]       r_cum_high, n_cum_high;
    logic              r_bit, n_bit;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic [BYTE_W-1:0] r_byte, n_byte;
    logic              r_out_valid, n_out_valid;
    logic [BYTE_W-1:0] r_out_byte, n_out_byte;
    logic              r_out_last, n_out_last;

    logic              w_div_start;
    logic [WORD_W-1:0] w_quo;
    t_div_stat         w_div_stat;
    logic              w_mul_en;
    logic [WORD_W-1:0] w_mul_a;
    logic [WORD_W-1:0] w_mul_b;
    logic [WORD_W-1:0] w_prod;
    logic [WORD_W-1:0] w_sum;
    logic              w_cond1;
    logic              w_cond2;
    logic              w_needs;
    logic [WORD_W-1:0] w_range_c;
    logic              w_out_free;
    logic              w_out_load;
    logic              w_last;

    cre_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (r_range),
        .i_divisor  (i_total),
        .o_quotient (w_quo),
        .o_stat     (w_div_stat)
    );

    cre_mul u_mul (
        .i_clk  (i_clk),
        .i_en   (w_mul_en),
        .i_a    (w_mul_a),
        .i_b    (w_mul_b),
        .o_prod (w_prod)
    );

    assign w_sum     = r_low + r_range;
    assign w_cond1   = ((r_low ^ w_sum) >> TOP_BITS) == '0;
    assign w_cond2   = (r_range < BOT_VALUE);
    assign w_needs   = w_cond1 || w_cond2;
    assign w_range_c = (!w_cond1 && w_cond2) ? ((WORD_W'(0) - r_low) & BOT_MASK) : r_range;
    assign w_out_free = !r_out_valid || !i_stall;

    always_comb begin
        n_state     = r_state;
        n_low       = r_low;
        n_range     = r_range;
        n_q         = r_q;
        n_cum_low   = r_cum_low;
        n_cum_high  = r_cum_high;
        n_bit       = r_bit;
        n_cnt       = r_cnt;
        n_byte      = r_byte;
        n_out_valid = r_out_valid && i_stall;
        n_out_byte  = r_out_byte;
        n_out_last  = r_out_last;
        w_div_start = 1'b0;
        w_mul_en    = 1'b0;
        w_mul_a     = '0;
        w_mul_b     = '0;
        w_out_load  = 1'b0;
        w_last      = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_cum_low  = i_cum_low;
                    n_cum_high = i_cum_high;
                    n_bit      = i_bit_req;
                    n_cnt      = '0;
                    case (i_op)
                        OP_INTERVAL: begin
                            w_div_start = 1'b1;
                            n_state     = S_DIV;
                        end
                        OP_BINARY: begin
                            w_mul_en = 1'b1;
                            w_mul_a  = WORD_W'(i_f0);
                            w_mul_b  = r_range >> i_shift;
                            n_state  = S_BIN;
                        end
                        OP_FLUSH: begin
                            n_state = S_FLUSH;
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end
            S_DIV: begin
                if (w_div_stat.done) begin
                    w_mul_en = 1'b1;
                    w_mul_a  = w_quo;
                    w_mul_b  = WORD_W'(r_cum_low);
                    n_q      = w_quo;
                    n_state  = S_MUL1;
                end
            end
            S_MUL1: begin
                n_low    = r_low + w_prod;
                w_mul_en = 1'b1;
                w_mul_a  = r_q;
                w_mul_b  = WORD_W'(r_cum_high) - WORD_W'(r_cum_low);
                n_state  = S_MUL2;
            end
            S_MUL2: begin
                n_range = w_prod;
                n_state = S_NORM;
            end
            S_BIN: begin
                if (!r_bit) begin
                    n_range = w_prod;
                end else begin
                    n_low   = r_low + w_prod;
                    n_range = r_range - w_prod;
                end
                n_state = S_NORM;
            end
            S_NORM: begin
                if (w_needs) begin
                    n_byte  = r_low[WORD_W-1 -: BYTE_W];
                    n_low   = r_low << BYTE_W;
                    n_range = w_range_c << BYTE_W;
                    n_cnt   = r_cnt + CNT_W'(1);
                    n_state = S_LOOK;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_LOOK: begin
                if (w_out_free) begin
                    w_last      = (r_cnt == CNT_W'(MAX_EMIT)) || !w_needs;
                    w_out_load  = 1'b1;
                    n_out_valid = 1'b1;
                    n_out_byte  = r_byte;
                    n_out_last  = w_last;
                    n_state     = w_last ? S_IDLE : S_NORM;
                end
            end
            S_FLUSH: begin
                if (w_out_free) begin
                    w_last      = (r_cnt == CNT_W'(MAX_EMIT - 1));
                    w_out_load  = 1'b1;
                    n_out_valid = 1'b1;
                    n_out_byte  = r_low[WORD_W-1 -: BYTE_W];
                    n_out_last  = w_last;
                    n_low       = r_low << BYTE_W;
                    n_cnt       = r_cnt + CNT_W'(1);
                    n_state     = w_last ? S_IDLE : S_FLUSH;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_low       <= '0;
            r_range     <= '1;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_low       <= n_low;
            r_range     <= n_range;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
        r_q        <= n_q;
        r_cum_low  <= n_cum_low;
        r_cum_high <= n_cum_high;
        r_bit      <= n_bit;
        r_byte     <= n_byte;
        r_out_byte <= n_out_byte;
        r_out_last <= n_out_last;
    end

    assign o_stall    = (r_state != S_IDLE);
    assign o_valid    = r_out_valid;
    assign o_out_byte = r_out_byte;
    assign o_last     = r_out_last;

    `ASSERT_NEVER(a_no_overwrite, i_clk, i_rst_n, w_out_load && r_out_valid && i_stall)
    `ASSERT_NEVER(a_cnt_bound, i_clk, i_rst_n, r_cnt > CNT_W'(MAX_EMIT))
    `ASSERT_CLK(a_norm_below_max, i_clk, i_rst_n, (r_state == S_NORM) |-> (r_cnt < CNT_W'(MAX_EMIT)))
    `ASSERT_CLK(a_div_done_in_div, i_clk, i_rst_n, w_div_stat.done |-> (r_state == S_DIV))

endmodule

// ----- dv/tb_top.sv -----
// Self-checking testbench for the carryless range encoder top level.
// Depends on cre_pkg and carryless_range_encoder; predicts every output byte in place.
`timescale 1ns / 1ps

module tb_top;
    import cre_pkg::*;

    localparam int BOTTOM_BITS = 15;
    localparam int N_RANDOM    = 210;
    localparam int IDLE_LIMIT  = 2000;
    localparam int TAIL_CYCLES = 60;
    localparam int MAX_REPORTS = 10;
    localparam logic [OP_W-1:0] OP_NONE = 2'd3;
    localparam logic [31:0] BOT_VALUE = 32'd1 << BOTTOM_BITS;
    localparam logic [31:0] TOP_VALUE = 32'd1 << TOP_BITS;

    typedef struct packed {
        logic [OP_W-1:0] op;
        logic [14:0]     cum_low;
        logic [15:0]     cum_high;
        logic [15:0]     total;
        logic [15:0]     f0;
        logic [4:0]      shift;
        logic            bit_req;
    } t_enc_item;

    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              last;
    } t_enc_byte;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_valid = 1'b0;
    logic              o_stall;
    logic [OP_W-1:0]   i_op = '0;
    logic [14:0]       i_cum_low = '0;
    logic [15:0]       i_cum_high = '0;
    logic [15:0]       i_total = '0;
    logic [15:0]       i_f0 = '0;
    logic [4:0]        i_shift = '0;
    logic              i_bit_req = 1'b0;
    logic              o_valid;
    logic              i_stall = 1'b0;
    logic [BYTE_W-1:0] o_out_byte;
    logic              o_last;

    t_enc_item pending_items[$];
    t_enc_byte expected_bytes[$];
    logic [31:0] enc_low = 32'd0;
    logic [31:0] enc_range = 32'hFFFF_FFFF;
    int n_items = 0;
    int n_accepted = 0;
    int err_cnt = 0;

    carryless_range_encoder #(
        .BOTTOM_BITS(BOTTOM_BITS)
    ) dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(i_valid),
        .o_stall(o_stall),
        .i_op(i_op),
        .i_cum_low(i_cum_low),
        .i_cum_high(i_cum_high),
        .i_total(i_total),
        .i_f0(i_f0),
        .i_shift(i_shift),
        .i_bit_req(i_bit_req),
        .o_valid(o_valid),
        .i_stall(i_stall),
        .o_out_byte(o_out_byte),
        .o_last(o_last)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    function automatic t_enc_item make_item(logic [OP_W-1:0] op, int cl, int ch, int tot,
                                            int f0, int sh, logic b);
        t_enc_item it;
        it.op = op;
        it.cum_low = cl[14:0];
        it.cum_high = ch[15:0];
        it.total = tot[15:0];
        it.f0 = f0[15:0];
        it.shift = sh[4:0];
        it.bit_req = b;
        return it;
    endfunction

    // Updates the interval state for one item and queues the bytes it must produce.
    task automatic encode_item(input t_enc_item it);
        logic [BYTE_W-1:0] bytes[MAX_EMIT];
        logic [31:0] quot;
        logic [31:0] part;
        logic [31:0] split;
        logic renorm;
        int n;
        n = 0;
        if (it.op == OP_INTERVAL) begin
            quot = (it.total == 16'd0) ? 32'hFFFF_FFFF : enc_range / {16'd0, it.total};
            enc_low = enc_low + {17'd0, it.cum_low} * quot;
            enc_range = quot * ({16'd0, it.cum_high} - {17'd0, it.cum_low});
        end else if (it.op == OP_BINARY) begin
            part = enc_range >> it.shift;
            split = {16'd0, it.f0} * part;
            if (it.bit_req) begin
                enc_low = enc_low + split;
                enc_range = enc_range - split;
            end else begin
                enc_range = split;
            end
        end
        if (it.op == OP_INTERVAL || it.op == OP_BINARY) begin
            while (n < MAX_EMIT) begin
                renorm = 1'b0;
                if ((enc_low ^ (enc_low + enc_range)) < TOP_VALUE) begin
                    renorm = 1'b1;
                end else if (enc_range < BOT_VALUE) begin
                    enc_range = (32'd0 - enc_low) & (BOT_VALUE - 32'd1);
                    renorm = 1'b1;
                end
                if (!renorm) break;
                bytes[n] = enc_low[31:24];
                enc_range = enc_range << 8;
                enc_low = enc_low << 8;
                n++;
            end
        end else if (it.op == OP_FLUSH) begin
            for (n = 0; n < MAX_EMIT; n++) begin
                bytes[n] = enc_low[31:24];
                enc_low = enc_low << 8;
            end
        end
        for (int i = 0; i < n; i++) begin
            expected_bytes.push_back('{data: bytes[i], last: (i == n - 1)});
        end
    endtask

    // Input side: bursts of transfers separated by random gaps.
    t_enc_item cur_item;
    int burst_left = 0;
    int gap_left = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && !o_stall) begin
                encode_item(cur_item);
                n_accepted++;
            end
            if (!i_valid || !o_stall) begin
                if (burst_left == 0) begin
                    burst_left = $urandom_range(1, 30);
                    gap_left = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 20);
                end
                if (gap_left > 0 || pending_items.size() == 0) begin
                    if (gap_left > 0) gap_left--;
                    i_valid <= 1'b0;
                end else begin
                    cur_item = pending_items.pop_front();
                    burst_left--;
                    i_valid <= 1'b1;
                    i_op <= cur_item.op;
                    i_cum_low <= cur_item.cum_low;
                    i_cum_high <= cur_item.cum_high;
                    i_total <= cur_item.total;
                    i_f0 <= cur_item.f0;
                    i_shift <= cur_item.shift;
                    i_bit_req <= cur_item.bit_req;
                end
            end
        end
    end

    // Output side: stall pattern changes mode every phase, with runs capped in length.
    int stall_mode = 0;
    int phase_left = 0;
    int stall_run = 0;
    int pattern_cnt = 0;

    always @(posedge i_clk) begin
        logic nxt;
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (phase_left == 0) begin
                stall_mode = $urandom_range(0, 3);
                phase_left = $urandom_range(20, 200);
            end
            phase_left--;
            pattern_cnt++;
            case (stall_mode)
                0: nxt = 1'b0;
                1: nxt = 1'($urandom_range(0, 1));
                2: nxt = ($urandom_range(0, 3) != 0);
                default: nxt = ((pattern_cnt % 7) < 4);
            endcase
            if (stall_run >= 16) nxt = 1'b0;
            stall_run = nxt ? stall_run + 1 : 0;
            i_stall <= nxt;
        end
    end

    always @(posedge i_clk) begin
        t_enc_byte want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_bytes.size() == 0) begin
                if (err_cnt < MAX_REPORTS)
                    $display("Unexpected output byte %02h last %0b", o_out_byte, o_last);
                err_cnt++;
            end else begin
                want = expected_bytes.pop_front();
                if (o_out_byte !== want.data || o_last !== want.last) begin
                    if (err_cnt < MAX_REPORTS)
                        $display("Mismatch: expected byte %02h last %0b, got byte %02h last %0b",
                                 want.data, want.last, o_out_byte, o_last);
                    err_cnt++;
                end
            end
        end
    end

    int idle_cycles = 0;

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_valid && !o_stall) || (o_valid && !i_stall)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("Timeout: no transfer for %0d cycles", IDLE_LIMIT);
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    initial begin
        t_enc_item it;
        int tot;
        int ch;
        int sh;
        int pick;

        // Directed part: field extremes, every operation and the corner cases.
        pending_items.push_back(make_item(OP_INTERVAL, 0, 1, 32768, 0, 0, 0));
        pending_items.push_back(make_item(OP_INTERVAL, 32767, 32768, 32768, 0, 0, 0));
        pending_items.push_back(make_item(OP_INTERVAL, 0, 65535, 65535, 65535, 31, 1));
        pending_items.push_back(make_item(OP_INTERVAL, 100, 200, 0, 0, 0, 0));
        pending_items.push_back(make_item(OP_INTERVAL, 5000, 10, 16384, 0, 0, 0));
        pending_items.push_back(make_item(OP_INTERVAL, 3, 0, 7, 0, 0, 0));
        pending_items.push_back(make_item(OP_INTERVAL, 0, 1, 1, 0, 0, 0));
        pending_items.push_back(make_item(OP_FLUSH, 32767, 65535, 65535, 65535, 31, 1));
        pending_items.push_back(make_item(OP_BINARY, 0, 0, 0, 0, 0, 0));
        pending_items.push_back(make_item(OP_BINARY, 0, 0, 0, 65535, 16, 1));
        pending_items.push_back(make_item(OP_BINARY, 0, 0, 0, 1, 31, 0));
        pending_items.push_back(make_item(OP_BINARY, 0, 0, 0, 2048, 12, 0));
        pending_items.push_back(make_item(OP_BINARY, 0, 0, 0, 2048, 12, 1));
        pending_items.push_back(make_item(OP_BINARY, 0, 0, 0, 65535, 0, 1));
        pending_items.push_back(make_item(OP_NONE, 32767, 65535, 65535, 65535, 31, 1));
        pending_items.push_back(make_item(OP_BINARY, 0, 0, 0, 1, 16, 1));
        pending_items.push_back(make_item(OP_INTERVAL, 1, 2, 3, 0, 0, 0));
        pending_items.push_back(make_item(OP_FLUSH, 0, 0, 0, 0, 0, 0));
        pending_items.push_back(make_item(OP_FLUSH, 0, 0, 0, 0, 0, 0));
        pending_items.push_back(make_item(OP_INTERVAL, 32767, 1, 1, 0, 0, 0));

        for (int k = 0; k < N_RANDOM; k++) begin
            it.op = OP_INTERVAL;
            it.cum_low = 15'($urandom);
            it.cum_high = 16'($urandom);
            it.total = 16'($urandom);
            it.f0 = 16'($urandom);
            it.shift = 5'($urandom);
            it.bit_req = 1'($urandom);
            pick = $urandom_range(0, 99);
            if (pick < 50) begin
                if ($urandom_range(0, 1))
                    tot = 1 << $urandom_range(0, 15);
                else
                    tot = $urandom_range(1, 32768);
                ch = $urandom_range(1, tot);
                it.total = tot[15:0];
                it.cum_high = ch[15:0];
                it.cum_low = 15'($urandom_range(0, ch - 1));
            end else if (pick < 85) begin
                sh = $urandom_range(1, 16);
                it.op = OP_BINARY;
                it.shift = sh[4:0];
                it.f0 = (sh == 1) ? 16'd1 : 16'($urandom_range(1, (1 << sh) - 1));
            end else if (pick < 90) begin
                it.op = OP_FLUSH;
            end else if (pick < 93) begin
                it.op = OP_NONE;
            end else begin
                it.op = $urandom_range(0, 1) ? OP_BINARY : OP_INTERVAL;
            end
            pending_items.push_back(it);
        end
        n_items = pending_items.size();

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (n_accepted < n_items) @(posedge i_clk);
        while (expected_bytes.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (err_cnt == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

// ----- files.f -----
+incdir+design
design/cre_pkg.sv
design/cre_div.sv
design/cre_mul.sv
design/carryless_range_encoder.sv
dv/tb_top.sv
